// ===== sv/ilir_pkg.sv =====
package ilir_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int WORD_W       = 32;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 6;

    typedef enum logic [1:0] {
        FUNC_GET    = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_INSERT = 2'd2,
        FUNC_REMOVE = 2'd3
    } func_t;

    typedef struct packed {
        logic                ins;
        logic                rem;
        logic                wr;
        logic [INDEX_W-1:0]  index;
        logic [WORD_W-1:0]   value;
    } cmd_t;

endpackage

// ===== sv/indexed_list_insert_remove.sv =====
// Ordered list of signed 32-bit words in a row of CAPACITY register cells,
// with get, set, insert and remove by index. Insert and remove shift every
// later cell by one position in place, all cells at once: an item accepted
// at one edge gives its result, marked by done, for exactly the next cycle,
// and busy stays low, so a new item may be started in every cycle. Results
// cannot be stalled; the receiver must take each one in the cycle done is
// high. Rejected requests (index out of range, insert into a full list)
// change nothing and report ok low; a failed get reads all ones. count is
// the element count after the request, low 6 bits.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                func,
    input  logic [INDEX_W-1:0]        index,
    input  logic signed [WORD_W-1:0]  value,
    output logic                      done,
    output logic signed [WORD_W-1:0]  read_value,
    output logic                      ok,
    output logic [COUNT_W-1:0]        count
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW0 = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int IW  = (CW > IW0) ? CW : IW0;
    localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [WORD_W-1:0] read_reg;
    logic [WORD_W-1:0] read_next;
    logic [WORD_W-1:0] slot_data [CAPACITY];
    logic              accept;
    logic [IW-1:0]     idx_ext;
    logic [IW-1:0]     cnt_ext;
    logic              in_range;
    logic              can_insert;
    cmd_t              cmd;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign idx_ext = IW'(index);
    assign cnt_ext = IW'(count_reg);
    assign in_range   = (idx_ext < cnt_ext);
    assign can_insert = (count_reg < CAP_V) && (idx_ext <= cnt_ext);

    always_comb
    begin
        cmd        = '0;
        cmd.index  = index;
        cmd.value  = value;
        count_next = count_reg;
        ok_next    = 1'b0;
        read_next  = '0;
        unique case (func_t'(func))
            FUNC_GET:
            begin
                if (in_range)
                begin
                    ok_next   = 1'b1;
                    read_next = slot_data[idx_ext[AW-1:0]];
                end
                else
                begin
                    read_next = '1;
                end
            end
            FUNC_SET:
            begin
                ok_next = in_range;
                cmd.wr  = accept && in_range;
            end
            FUNC_INSERT:
            begin
                ok_next = can_insert;
                cmd.ins = accept && can_insert;
                if (can_insert)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_REMOVE:
            begin
                ok_next = in_range;
                cmd.rem = accept && in_range;
                if (in_range)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_W-1:0] left_d;
        logic [WORD_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = slot_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = slot_data[g];
        end
        else
        begin : g_mid_r
            assign right_d = slot_data[g+1];
        end

        ilir_cell #(
            .POS (g),
            .IW  (IW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (slot_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg   <= ok_next;
            read_reg <= read_next;
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign read_value = read_reg;
    assign count      = COUNT_W'(count_reg);

endmodule

// ===== sv/ilir_cell.sv =====
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int POS = 0,
    parameter int IW  = 8
)
(
    input  logic              clk,
    input  cmd_t              cmd,
    input  logic [WORD_W-1:0] left_data,
    input  logic [WORD_W-1:0] right_data,
    output logic [WORD_W-1:0] data
);

    localparam logic [IW-1:0] POS_V = IW'(POS);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [IW-1:0]     idx;
    logic              at_idx;
    logic              past_idx;

    assign idx      = IW'(cmd.index);
    assign at_idx   = (POS_V == idx);
    assign past_idx = (POS_V > idx);

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.ins && past_idx)
        begin
            data_next = left_data;
        end
        else if ((cmd.ins || cmd.wr) && at_idx)
        begin
            data_next = cmd.value;
        end
        else if (cmd.rem && (past_idx || at_idx))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/ilir_checker.sv =====
module ilir_checker
    import ilir_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                func,
    input logic                      done,
    input logic signed [WORD_W-1:0]  read_value,
    input logic                      ok,
    input logic [COUNT_W-1:0]        count
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("item accepted without a result");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without an item");

    a_failed_get: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok && ($past(func) == FUNC_GET)) |-> (read_value == -1))
        else $error("failed get must read all ones");

    a_non_get_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func) != FUNC_GET)) |-> (read_value == 0))
        else $error("read value must be zero for non-get");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok && ($past(func) == FUNC_INSERT))
            |-> (count == COUNT_W'($past(count) + COUNT_W'(1))))
        else $error("insert must raise count by one");

endmodule

bind indexed_list_insert_remove ilir_checker u_ilir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .done       (done),
    .read_value (read_value),
    .ok         (ok),
    .count      (count)
);
